// File: rtl/core/ray_reflect_refract_direction_macros.svh
// assertion macros for the ray direction pipeline
// used by ray_reflect_refract_direction, no other dependencies
`ifndef RAY_REFLECT_REFRACT_DIRECTION_MACROS_SVH
`define RAY_REFLECT_REFRACT_DIRECTION_MACROS_SVH
`ifndef SYNTH
`define RRD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RRD_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define RRD_ASSERT(lbl, clk, rstn, prop, msg)
`define RRD_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// File: rtl/core/rrd_pkg.sv
// types and constants for the ray reflect / refract direction pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package rrd_pkg;

    localparam int FRAC_BITS = 14;
    localparam int N_STAGES  = 14;

    typedef enum logic {
        ACT_REFLECT = 1'b0,
        ACT_REFRACT = 1'b1
    } action_t;

    typedef struct packed {
        action_t          act;
        logic [2:0][15:0] d;
        logic [2:0][15:0] n;
        logic [15:0]      eta;
        logic [2:0][31:0] dn;
        logic [31:0]      eta2;
        logic [2:0][32:0] ed;
        logic [33:0]      dot;
        logic [18:0]      dq;
        logic [18:0]      c;
        logic [2:0][18:0] edr;
        logic [2:0][34:0] dqn;
        logic [37:0]      cc;
        logic [35:0]      ec;
        logic [2:0][21:0] refl;
        logic [22:0]      s;
        logic [21:0]      ecr;
        logic [55:0]      q;
        logic [39:0]      rad;
        logic [19:0]      root;
        logic [22:0]      rem;
        logic [22:0]      m;
        logic [2:0][38:0] nm;
        logic [2:0][19:0] res;
        logic             clip;
    } pipe_t;

endpackage
`default_nettype wire

// File: rtl/core/ray_reflect_refract_direction.sv
// ray reflect / refract direction unit, one fourteen-stage pipeline
// depends on rrd_pkg and ray_reflect_refract_direction_macros.svh
//
// usage:
//   s_ side, unless stalled, takes one request per cycle: s_tuser is the
//   action (0 reflect, 1 refract), s_tdata holds direction, normal and
//   eta ratio (Q2.14). m_ side gives one result per request, in order:
//   m_tdata holds the saturated Q6.14 direction, m_tuser flags saturation.
//   throughput is one request per cycle while the receiver does not stall,
//   set by the fully pipelined datapath, whose square root resolves four
//   root bits in each of five stages.
//   when the receiver stalls with a result waiting, every stage holds and
//   s_tready drops in the same cycle; bubbles never block acceptance.
//   reset clears all stage valid bits; the pipeline comes up empty and
//   ready.
`timescale 1ns / 1ps
`default_nettype none
`include "ray_reflect_refract_direction_macros.svh"
module ray_reflect_refract_direction
    import rrd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, eta_ratio
    input  wire logic [111:0] s_tdata,
    // action
    input  wire logic [0:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_x, out_y, out_z, zero pad
    output logic [63:0]       m_tdata,
    // clipped
    output logic [0:0]        m_tuser
);

    localparam int LAST = N_STAGES - 1;
    localparam logic signed [33:0] HALF34 = 34'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [32:0] HALF33 = 33'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [35:0] HALF36 = 36'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [37:0] HALF38 = 38'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [38:0] HALF39 = 39'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [55:0] HALF56 = 56'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [18:0] ONE19  = 19'sd1 <<< FRAC_BITS;
    localparam logic signed [37:0] ONE38  = 38'sd1 <<< (2 * FRAC_BITS);
    localparam logic signed [41:0] ONE42  = 42'sd1 <<< (2 * FRAC_BITS);
    localparam logic signed [25:0] OUT_MAX = 26'sd524287;
    localparam logic signed [25:0] OUT_MIN = -26'sd524288;

    pipe_t pipe_reg  [N_STAGES];
    pipe_t pipe_next [N_STAGES];
    logic [N_STAGES-1:0] valid_reg;
    logic advance;

    assign advance  = !valid_reg[LAST] || m_tready;
    assign s_tready = advance;

    always_comb begin
        logic signed [33:0] t_dot;
        logic signed [33:0] t_neg;
        logic signed [18:0] c_full;
        logic signed [32:0] t_ed;
        logic signed [35:0] t_36;
        logic signed [37:0] t_38;
        logic signed [55:0] t_56;
        logic signed [41:0] k2;
        logic [23:0] rem_sh;
        logic [23:0] trial;
        logic signed [38:0] t_39;
        logic signed [25:0] r;
        pipe_t p;

        // input products
        p = pipe_reg[0];
        p.act = action_t'(s_tuser[0]);
        p.d[0] = s_tdata[15:0];
        p.d[1] = s_tdata[31:16];
        p.d[2] = s_tdata[47:32];
        p.n[0] = s_tdata[63:48];
        p.n[1] = s_tdata[79:64];
        p.n[2] = s_tdata[95:80];
        p.eta  = s_tdata[111:96];
        for (int i = 0; i < 3; i++) begin
            p.dn[i] = $signed(p.d[i]) * $signed(p.n[i]);
            p.ed[i] = $signed({1'b0, p.eta}) * $signed(p.d[i]);
        end
        p.eta2 = p.eta * p.eta;
        pipe_next[0] = p;

        // dot product, cosine and eta*d rounding
        p = pipe_reg[0];
        p.dot = $signed(p.dn[0]) + $signed(p.dn[1]) + $signed(p.dn[2]);
        t_dot = $signed(p.dot) + HALF34;
        p.dq = t_dot[FRAC_BITS+18:FRAC_BITS];
        t_neg = -$signed(p.dot) + HALF34;
        c_full = t_neg[FRAC_BITS+18:FRAC_BITS];
        p.c = (c_full > ONE19) ? ONE19 : c_full;
        for (int i = 0; i < 3; i++) begin
            t_ed = $signed(p.ed[i]) + HALF33;
            p.edr[i] = t_ed[FRAC_BITS+18:FRAC_BITS];
        end
        pipe_next[1] = p;

        p = pipe_reg[1];
        for (int i = 0; i < 3; i++) begin
            p.dqn[i] = $signed(p.dq) * $signed(p.n[i]);
        end
        p.cc = $signed(p.c) * $signed(p.c);
        p.ec = $signed({1'b0, p.eta}) * $signed(p.c);
        pipe_next[2] = p;

        // reflected vector, sine squared
        p = pipe_reg[2];
        for (int i = 0; i < 3; i++) begin
            t_36 = $signed({p.dqn[i], 1'b0}) + HALF36;
            p.refl[i] = $signed(p.d[i]) - $signed(t_36[FRAC_BITS+21:FRAC_BITS]);
        end
        t_38 = ONE38 - $signed(p.cc) + HALF38;
        p.s = t_38[FRAC_BITS+22:FRAC_BITS];
        t_36 = $signed(p.ec) + HALF36;
        p.ecr = t_36[FRAC_BITS+21:FRAC_BITS];
        pipe_next[3] = p;

        p = pipe_reg[3];
        p.q = $signed({1'b0, p.eta2}) * $signed(p.s);
        pipe_next[4] = p;

        // radicand magnitude
        p = pipe_reg[4];
        t_56 = $signed(p.q) + HALF56;
        k2 = ONE42 - $signed(t_56[FRAC_BITS+41:FRAC_BITS]);
        p.rad = k2[41] ? 40'(-k2) : 40'(k2);
        p.root = '0;
        p.rem = '0;
        pipe_next[5] = p;

        // square root, four bits per stage
        for (int k = 6; k <= 10; k++) begin
            p = pipe_reg[k-1];
            for (int j = 0; j < 4; j++) begin
                rem_sh = {p.rem[21:0], p.rad[39:38]};
                trial = rem_sh - {2'b00, p.root, 2'b01};
                if (!trial[23]) begin
                    p.rem = trial[22:0];
                    p.root = {p.root[18:0], 1'b1};
                end else begin
                    p.rem = rem_sh[22:0];
                    p.root = {p.root[18:0], 1'b0};
                end
                p.rad = {p.rad[37:0], 2'b00};
            end
            pipe_next[k] = p;
        end

        p = pipe_reg[10];
        p.m = $signed(p.ecr) - $signed({1'b0, p.root});
        pipe_next[11] = p;

        p = pipe_reg[11];
        for (int i = 0; i < 3; i++) begin
            p.nm[i] = $signed(p.n[i]) * $signed(p.m);
        end
        pipe_next[12] = p;

        // final sum (refract) or reflected vector (reflect), and saturation
        p = pipe_reg[12];
        p.clip = 1'b0;
        for (int i = 0; i < 3; i++) begin
            t_39 = $signed(p.nm[i]) + HALF39;
            if (p.act == ACT_REFLECT) begin
                r = $signed(p.refl[i]);
            end else begin
                r = $signed(p.edr[i]) + $signed(t_39[FRAC_BITS+24:FRAC_BITS]);
            end
            if (r > OUT_MAX) begin
                r = OUT_MAX;
                p.clip = 1'b1;
            end
            if (r < OUT_MIN) begin
                r = OUT_MIN;
                p.clip = 1'b1;
            end
            p.res[i] = r[19:0];
        end
        pipe_next[13] = p;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[N_STAGES-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int k = 0; k < N_STAGES; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = {4'b0000, pipe_reg[LAST].res[2], pipe_reg[LAST].res[1],
                       pipe_reg[LAST].res[0]};
    assign m_tuser  = pipe_reg[LAST].clip;

    `RRD_ASSERT(a_hold, aclk, aresetn, valid_reg[LAST] && !m_tready |=> valid_reg[LAST] && $stable(pipe_reg[LAST].res), "stalled result lost or changed")
    `RRD_ASSERT(a_clip, aclk, aresetn, m_tvalid && m_tuser[0] |-> m_tdata[19:0] == 20'h7FFFF || m_tdata[19:0] == 20'h80000 || m_tdata[39:20] == 20'h7FFFF || m_tdata[39:20] == 20'h80000 || m_tdata[59:40] == 20'h7FFFF || m_tdata[59:40] == 20'h80000, "clip flag without a saturated component")
    `RRD_ASSERT(a_cos, aclk, aresetn, valid_reg[1] |-> $signed(pipe_reg[1].c) <= ONE19, "cosine above one")
    `RRD_NEVER(a_root, aclk, aresetn, valid_reg[10] && (pipe_reg[10].rem > 23'(pipe_reg[10].root) * 2), "square root remainder out of range")

endmodule
`default_nettype wire
